// File: design/wstc_pkg.sv
package wstc_pkg;

   // input commands carried on the request tuser
   typedef enum logic [1:0] {
      CMD_DATA = 2'd0,
      CMD_SOF  = 2'd1,
      CMD_EOF  = 2'd2
   } cmd_type;

   // result kinds carried on the response tuser
   localparam logic KIND_TEXT   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // special text bytes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_HASH    = 8'h23;

   // tag window: newest byte at index 0, tags stored reversed
   localparam int TagWin = 10;
   typedef logic [TagWin-1:0][7:0] tag_pat_type;

   localparam tag_pat_type TAG_NAME     = {32'd0, "[NAME]"};
   localparam tag_pat_type TAG_RELATION = "[RELATION]";
   localparam tag_pat_type TAG_CONS     = {32'd0, "[CONS]"};
   localparam tag_pat_type TAG_END      = {40'd0, "[END]"};

   localparam logic [3:0] LEN_NAME     = 4'd6;
   localparam logic [3:0] LEN_RELATION = 4'd10;
   localparam logic [3:0] LEN_CONS     = 4'd6;
   localparam logic [3:0] LEN_END      = 4'd5;

   // result queue depth, room for two results per item plus backlog
   localparam int QDepth = 4;

   // section flags, sticky but for open, name in the lowest bit
   typedef struct packed {
      logic failed;
      logic open;
      logic cons;
      logic relation;
      logic name;
   } flags_type;

   typedef struct packed {
      logic       kind;
      logic       last;
      flags_type  flags;
      logic [7:0] out_byte;
   } result_type;

   // ascii letters to upper case, everything else unchanged
   function automatic logic [7:0] upcase(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h61 && b <= 8'h7a) begin
         r = b - 8'h20;
      end
      return r;
   endfunction

   // compare the first len window bytes against a reversed tag
   function automatic logic tag_match(input tag_pat_type win, input tag_pat_type pat,
                                      input logic [3:0] len);
      logic hit;
      hit = 1'b1;
      for (int i = 0; i < TagWin; i++) begin
         if (4'(i) < len && upcase(win[i]) != pat[i]) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage

// File: design/wstc_tag_track.sv
module wstc_tag_track #(
   parameter int HISTORY_LEN = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic [7:0]          data_byte,
   output wstc_pkg::flags_type flags_ff,
   output wstc_pkg::flags_type flags_in
);

   logic [7:0]            hist_ff [HISTORY_LEN];
   wstc_pkg::tag_pat_type win;
   logic                  hit_name;
   logic                  hit_relation;
   logic                  hit_cons;
   logic                  hit_end;

   // window as it looks after the new byte is shifted in
   always_comb begin
      win[0] = data_byte;
      for (int i = 1; i < wstc_pkg::TagWin; i++) begin
         win[i] = hist_ff[i-1];
      end
   end

   assign hit_name     = wstc_pkg::tag_match(win, wstc_pkg::TAG_NAME, wstc_pkg::LEN_NAME);
   assign hit_relation = wstc_pkg::tag_match(win, wstc_pkg::TAG_RELATION,
                                             wstc_pkg::LEN_RELATION);
   assign hit_cons     = wstc_pkg::tag_match(win, wstc_pkg::TAG_CONS, wstc_pkg::LEN_CONS);
   assign hit_end      = wstc_pkg::tag_match(win, wstc_pkg::TAG_END, wstc_pkg::LEN_END);

   // section flag update, first matching tag wins
   always_comb begin
      flags_in = flags_ff;
      if (shift_en) begin
         if (hit_name || hit_relation || hit_cons) begin
            if (flags_ff.open) begin
               flags_in.failed = 1'b1;
            end
            flags_in.open = 1'b1;
            if (hit_name) begin
               flags_in.name = 1'b1;
            end else if (hit_relation) begin
               flags_in.relation = 1'b1;
            end else begin
               flags_in.cons = 1'b1;
            end
         end else if (hit_end) begin
            if (flags_ff.open) begin
               flags_in.open = 1'b0;
            end else begin
               flags_in.failed = 1'b1;
            end
         end
      end
   end

   // byte history and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         for (int i = 0; i < HISTORY_LEN; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         flags_ff <= flags_in;
         if (shift_en) begin
            hist_ff[0] <= data_byte;
            for (int i = 1; i < HISTORY_LEN; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
      end
   end

endmodule

// File: design/whitespace_squeeze_tag_checker.sv
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser cmd, tdata data_byte
// rsp       out  rsp_tvalid/rsp_tready  tuser kind, tlast last, tdata byte and flags
// csr       in   csr_valid/csr_ready    csr_data check_mode
//
// one request is taken per cycle; its results land in a four-entry queue at the same edge
// and appear on rsp from the next cycle, one per cycle unless rsp stalls; an item with a
// separator pushes two results, so req_tready drops while the queue holds three or more;
// synchronous active-high reset empties the queue, clears line and section state,
// and sets check_mode; rsp stalls only back up req through the queue level
module whitespace_squeeze_tag_checker #(
   parameter int HISTORY_LEN = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // [1:0] cmd
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,  // [0] kind
   output logic        rsp_tlast,
   output logic [15:0] rsp_tdata,  // [7:0] out_byte, [8] name_seen, [9] relation_seen,
                                   // [10] cons_seen, [11] section_open, [12] check_failed
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data    // [0] check_mode
);

   localparam int PtrW = $clog2(wstc_pkg::QDepth);
   localparam int CntW = $clog2(wstc_pkg::QDepth + 1);

   logic                 check_mode_ff;
   logic                 line_started_ff, line_started_in;
   logic                 pend_nl_ff, pend_nl_in;
   logic                 pend_sp_ff, pend_sp_in;
   logic                 in_comment_ff, in_comment_in;
   logic                 req_xfer;
   logic                 rsp_xfer;
   logic                 shift_en;
   logic [1:0]           push_cnt;
   wstc_pkg::result_type res0;
   wstc_pkg::result_type res1;
   wstc_pkg::flags_type  flags_ff;
   wstc_pkg::flags_type  flags_in;
   wstc_pkg::result_type queue_ff [wstc_pkg::QDepth];
   logic [PtrW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]      count_ff, count_in;

   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= CntW'(wstc_pkg::QDepth - 2));
   assign csr_ready  = 1'b1;
   assign shift_en   = req_xfer && check_mode_ff &&
                       (req_tuser == wstc_pkg::CMD_DATA);

   wstc_tag_track #(
      .HISTORY_LEN(HISTORY_LEN)
   ) u_tag_track (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .data_byte(req_tdata),
      .flags_ff (flags_ff),
      .flags_in (flags_in)
   );

   // per-item decode: line flags and the results it pushes
   always_comb begin
      logic visible;
      line_started_in = line_started_ff;
      pend_nl_in      = pend_nl_ff;
      pend_sp_in      = pend_sp_ff;
      in_comment_in   = in_comment_ff;
      push_cnt        = 2'd0;
      visible         = 1'b0;
      res0.kind       = wstc_pkg::KIND_TEXT;
      res0.last       = 1'b1;
      res0.flags      = flags_in;
      res0.out_byte   = req_tdata;
      res1            = res0;
      if (req_xfer) begin
         unique case (req_tuser)
            wstc_pkg::CMD_SOF: begin
               line_started_in = 1'b0;
               pend_nl_in      = 1'b0;
               pend_sp_in      = 1'b0;
               in_comment_in   = 1'b0;
            end
            wstc_pkg::CMD_EOF: begin
               res0.kind     = wstc_pkg::KIND_REPORT;
               res0.out_byte = '0;
               push_cnt      = 2'd1;
            end
            wstc_pkg::CMD_DATA: begin
               if (req_tdata == wstc_pkg::CHAR_NEWLINE) begin
                  pend_nl_in = 1'b1;
                  if (check_mode_ff) begin
                     in_comment_in = 1'b0;
                  end
               end else if (check_mode_ff && in_comment_ff) begin
                  visible = 1'b0;
               end else if (check_mode_ff && req_tdata == wstc_pkg::CHAR_HASH) begin
                  in_comment_in = 1'b1;
               end else if (req_tdata == wstc_pkg::CHAR_SPACE) begin
                  pend_sp_in = 1'b1;
               end else begin
                  visible = 1'b1;
               end
            end
            default: begin
               visible = 1'b0;
            end
         endcase
      end
      // a visible byte, with one separator ahead of it once a line has started and a gap is pending
      if (visible) begin
         line_started_in = 1'b1;
         pend_nl_in      = 1'b0;
         pend_sp_in      = 1'b0;
         if (line_started_ff && (pend_nl_ff || pend_sp_ff)) begin
            res0.last     = 1'b0;
            res0.out_byte = pend_nl_ff ? wstc_pkg::CHAR_NEWLINE : wstc_pkg::CHAR_SPACE;
            push_cnt      = 2'd2;
         end else begin
            push_cnt = 2'd1;
         end
      end
   end

   assign count_in = count_ff + CntW'(push_cnt) - CntW'(rsp_xfer);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         check_mode_ff   <= 1'b1;
         line_started_ff <= 1'b0;
         pend_nl_ff      <= 1'b0;
         pend_sp_ff      <= 1'b0;
         in_comment_ff   <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            check_mode_ff <= csr_data;
         end
         line_started_ff <= line_started_in;
         pend_nl_ff      <= pend_nl_in;
         pend_sp_ff      <= pend_sp_in;
         in_comment_ff   <= in_comment_in;
         wr_ptr_ff       <= wr_ptr_ff + PtrW'(push_cnt);
         rd_ptr_ff       <= rd_ptr_ff + PtrW'(rsp_xfer);
         count_ff        <= count_in;
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrW'(1)] <= res1;
      end
   end

   // response port
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;
   assign rsp_tdata  = {3'b000, queue_ff[rd_ptr_ff].flags, queue_ff[rd_ptr_ff].out_byte};

endmodule

// File: design/wstc_checker.sv
module wstc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic [15:0] rsp_tdata
);

   // queue comes out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // an end-of-file report is a lone result with a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == wstc_pkg::KIND_REPORT) |->
         rsp_tlast && (rsp_tdata[7:0] == 8'h00))
      else $error("malformed end-of-file report");

   // a non-final result is always a separator ahead of a text byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         (rsp_tuser == wstc_pkg::KIND_TEXT) &&
         ((rsp_tdata[7:0] == wstc_pkg::CHAR_SPACE) ||
          (rsp_tdata[7:0] == wstc_pkg::CHAR_NEWLINE)))
      else $error("non-final result is not a separator");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind whitespace_squeeze_tag_checker wstc_checker u_wstc_checker (.*);

// File: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // command code that the block ignores
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int HIST_LEN = 10;
   localparam int PHASES = 7;
   localparam int PHASE_ITEMS = 250;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
   } text_item_type;

   // one directed row; want is the final result when pinned is set
   typedef struct packed {
      logic [1:0]           cmd;
      logic [7:0]           data;
      logic                 pinned;
      wstc_pkg::result_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = wstc_pkg::CMD_DATA;  // [1:0] cmd
   logic [7:0]  req_tdata = 8'h00;               // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;             // [0] kind
   logic        rsp_tlast;
   logic [15:0] rsp_tdata;             // [7:0] out_byte, [8] name_seen, [9] relation_seen,
                                       // [10] cons_seen, [11] section_open, [12] check_failed
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;       // [0] check_mode

   // predicted block state
   logic [7:0]          recent [0:HIST_LEN-1];
   logic                line_open;
   logic                nl_due;
   logic                sp_due;
   logic                in_remark;
   wstc_pkg::flags_type sect;
   logic                strip_mode;

   wstc_pkg::result_type emit_q [$];
   text_item_type        text_q [$];
   dir_row_type          dir_rows [$];

   int  err_count = 0;
   int  cycles = 0;
   int  feed_count;
   bit  calm = 1'b0;

   whitespace_squeeze_tag_checker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // report one field, count on mismatch
   task automatic compare_field(input string what, input int got, input int want);
      if (got != want) begin
         err_count++;
         if (err_count <= PRINT_LIMIT) begin
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
         end
      end
   endtask

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      if (b >= "a" && b <= "z") begin
         return b - 8'h20;
      end
      return b;
   endfunction

   // newest byte sits at index 0, so the tag is read backwards
   function automatic logic tag_seen(input string tag);
      logic [7:0] ch;
      int n;
      n = tag.len();
      for (int i = 0; i < n; i++) begin
         ch = tag[n-1-i];
         if (to_upper(recent[i]) != ch) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void emit(input logic kind, input logic [7:0] b, input logic last);
      wstc_pkg::result_type r;
      r.kind = kind;
      r.last = last;
      r.flags = sect;
      r.out_byte = b;
      emit_q.push_back(r);
   endfunction

   // history shift and section tag bookkeeping
   function automatic void track_sections(input logic [7:0] b);
      logic opened;
      opened = 1'b0;
      for (int i = HIST_LEN - 1; i > 0; i--) begin
         recent[i] = recent[i-1];
      end
      recent[0] = b;
      if (tag_seen("[NAME]")) begin
         opened = 1'b1;
         sect.name = 1'b1;
      end else if (tag_seen("[RELATION]")) begin
         opened = 1'b1;
         sect.relation = 1'b1;
      end else if (tag_seen("[CONS]")) begin
         opened = 1'b1;
         sect.cons = 1'b1;
      end else if (tag_seen("[END]")) begin
         if (sect.open) begin
            sect.open = 1'b0;
         end else begin
            sect.failed = 1'b1;
         end
      end
      if (opened) begin
         if (sect.open) begin
            sect.failed = 1'b1;
         end
         sect.open = 1'b1;
      end
   endfunction

   // squeeze whitespace, strip comments, queue the bytes the block should send
   function automatic void squeeze_and_tag(input logic [1:0] cmd, input logic [7:0] b);
      if (cmd == wstc_pkg::CMD_SOF) begin
         line_open = 1'b0;
         nl_due = 1'b0;
         sp_due = 1'b0;
         in_remark = 1'b0;
         return;
      end
      if (cmd == wstc_pkg::CMD_EOF) begin
         emit(wstc_pkg::KIND_REPORT, 8'h00, 1'b1);
         return;
      end
      if (cmd != wstc_pkg::CMD_DATA) begin
         return;
      end
      if (strip_mode) begin
         track_sections(b);
         if (b == wstc_pkg::CHAR_NEWLINE) begin
            nl_due = 1'b1;
            in_remark = 1'b0;
            return;
         end
         if (in_remark) begin
            return;
         end
         if (b == wstc_pkg::CHAR_HASH) begin
            in_remark = 1'b1;
            return;
         end
      end else if (b == wstc_pkg::CHAR_NEWLINE) begin
         nl_due = 1'b1;
         return;
      end
      if (b == wstc_pkg::CHAR_SPACE) begin
         sp_due = 1'b1;
         return;
      end
      if (line_open && nl_due) begin
         emit(wstc_pkg::KIND_TEXT, wstc_pkg::CHAR_NEWLINE, 1'b0);
      end else if (line_open && sp_due) begin
         emit(wstc_pkg::KIND_TEXT, wstc_pkg::CHAR_SPACE, 1'b0);
      end
      line_open = 1'b1;
      nl_due = 1'b0;
      sp_due = 1'b0;
      emit(wstc_pkg::KIND_TEXT, b, 1'b1);
   endfunction

   // result check against the oldest expectation
   task automatic check_result();
      wstc_pkg::result_type want;
      if (emit_q.size() == 0) begin
         compare_field("result with none expected", 1, 0);
      end else begin
         want = emit_q.pop_front();
         compare_field("kind", rsp_tuser, want.kind);
         compare_field("out_byte", rsp_tdata[7:0], want.out_byte);
         compare_field("last", rsp_tlast, want.last);
         compare_field("name_seen", rsp_tdata[8], want.flags.name);
         compare_field("relation_seen", rsp_tdata[9], want.flags.relation);
         compare_field("cons_seen", rsp_tdata[10], want.flags.cons);
         compare_field("section_open", rsp_tdata[11], want.flags.open);
         compare_field("check_failed", rsp_tdata[12], want.flags.failed);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_result();
      end
   end

   // result side backpressure
   initial begin
      wait (reset == 1'b0);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // one input transfer, with an optional gap before it
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      squeeze_and_tag(cmd, data);
   endtask

   // mode write once the block has drained
   task automatic write_mode(input logic mode);
      req_tvalid <= 1'b0;
      while (emit_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      strip_mode = mode;
   endtask

   function automatic void add_item(input logic [1:0] cmd, input logic [7:0] data);
      text_item_type it;
      it.cmd = cmd;
      it.data = data;
      text_q.push_back(it);
      if (cmd != CMD_UNUSED) begin
         feed_count++;
      end
   endfunction

   function automatic logic [7:0] visible_char();
      logic [7:0] ch;
      ch = 8'($urandom_range(33, 126));
      if (ch == wstc_pkg::CHAR_HASH) begin
         ch = "Z";
      end
      return ch;
   endfunction

   function automatic void add_word();
      repeat ($urandom_range(1, 6)) add_item(wstc_pkg::CMD_DATA, visible_char());
   endfunction

   function automatic void add_gap();
      repeat ($urandom_range(1, 4)) begin
         add_item(wstc_pkg::CMD_DATA,
                  $urandom_range(0, 2) == 0 ? wstc_pkg::CHAR_NEWLINE : wstc_pkg::CHAR_SPACE);
      end
   endfunction

   // section tag in random letter case, optionally with one byte spoiled
   function automatic void add_tag(input bit spoil);
      string tag;
      logic [7:0] ch;
      int bad;
      case ($urandom_range(0, 3))
         0: tag = "[NAME]";
         1: tag = "[RELATION]";
         2: tag = "[CONS]";
         default: tag = "[END]";
      endcase
      bad = spoil ? $urandom_range(0, tag.len() - 1) : -1;
      for (int i = 0; i < tag.len(); i++) begin
         ch = tag[i];
         if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) begin
            ch = ch ^ 8'h20;
         end
         if (i == bad) begin
            ch = visible_char();
         end
         add_item(wstc_pkg::CMD_DATA, ch);
      end
   endfunction

   // comment body of raw bytes, sometimes with a tag inside
   function automatic void add_comment(input bit closed);
      logic [7:0] ch;
      add_item(wstc_pkg::CMD_DATA, wstc_pkg::CHAR_HASH);
      repeat ($urandom_range(0, 8)) begin
         ch = 8'($urandom_range(0, 255));
         if (ch == wstc_pkg::CHAR_NEWLINE) begin
            ch = wstc_pkg::CHAR_SPACE;
         end
         add_item(wstc_pkg::CMD_DATA, ch);
      end
      if ($urandom_range(0, 3) == 0) begin
         add_tag(1'b0);
      end
      if (closed) begin
         add_item(wstc_pkg::CMD_DATA, wstc_pkg::CHAR_NEWLINE);
      end
   endfunction

   // random text for one phase: words, gaps, tags, comments and some noise
   function automatic void build_phase();
      feed_count = 0;
      while (feed_count < PHASE_ITEMS) begin
         case ($urandom_range(0, 19)) inside
            [0:5]: add_word();
            [6:9]: add_gap();
            [10:12]: add_tag(1'b0);
            [13:14]: add_comment(1'b1);
            15: add_item(wstc_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
            16: add_item(wstc_pkg::CMD_SOF, 8'($urandom_range(0, 255)));
            17: add_item(wstc_pkg::CMD_EOF, 8'($urandom_range(0, 255)));
            18: add_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
            default: add_tag(1'b1);
         endcase
      end
      // leave a comment open across the next mode write now and then
      if ($urandom_range(0, 1) == 1) begin
         add_comment(1'b0);
      end
   endfunction

   // stimulus
   initial begin
      text_item_type it;
      dir_row_type row;

      // flags below are ordered failed, open, cons, relation, name
      dir_rows.push_back({wstc_pkg::CMD_EOF, 8'h00, 1'b1,
                          {wstc_pkg::KIND_REPORT, 1'b1, 5'b00000, 8'h00}});
      dir_rows.push_back({CMD_UNUSED, 8'ha5, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, wstc_pkg::CHAR_SPACE, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "a", 1'b1,
                          {wstc_pkg::KIND_TEXT, 1'b1, 5'b00000, "a"}});
      dir_rows.push_back({wstc_pkg::CMD_DATA, wstc_pkg::CHAR_SPACE, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, wstc_pkg::CHAR_NEWLINE, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "b", 1'b1,
                          {wstc_pkg::KIND_TEXT, 1'b1, 5'b00000, "b"}});
      dir_rows.push_back({wstc_pkg::CMD_DATA, wstc_pkg::CHAR_HASH, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "x", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, wstc_pkg::CHAR_NEWLINE, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "[", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "N", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "a", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "M", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "e", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "]", 1'b1,
                          {wstc_pkg::KIND_TEXT, 1'b1, 5'b01001, "]"}});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "[", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "e", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "N", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "d", 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, "]", 1'b1,
                          {wstc_pkg::KIND_TEXT, 1'b1, 5'b00001, "]"}});
      dir_rows.push_back({wstc_pkg::CMD_DATA, 8'h00, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_DATA, 8'hff, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_SOF, 8'h00, 1'b0, 15'd0});
      dir_rows.push_back({wstc_pkg::CMD_EOF, 8'hff, 1'b1,
                          {wstc_pkg::KIND_REPORT, 1'b1, 5'b00001, 8'h00}});

      // state after reset
      for (int i = 0; i < HIST_LEN; i++) begin
         recent[i] = 8'h00;
      end
      line_open = 1'b0;
      nl_due = 1'b0;
      sp_due = 1'b0;
      in_remark = 1'b0;
      sect = '0;
      strip_mode = 1'b1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, pinned ones replace the predicted final result
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_item(row.cmd, row.data);
         if (row.pinned && emit_q.size() != 0) begin
            emit_q[emit_q.size() - 1] = row.want;
         end
      end

      // random phases, alternating strip and squeeze-only modes
      for (int p = 0; p < PHASES; p++) begin
         write_mode(p % 2 == 0);
         if (p == PHASES - 1) begin
            calm = 1'b1;
         end
         build_phase();
         while (text_q.size() != 0) begin
            it = text_q.pop_front();
            send_item(it.cmd, it.data);
         end
      end

      // drain
      req_tvalid <= 1'b0;
      while (emit_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/wstc_pkg.sv
design/wstc_tag_track.sv
design/whitespace_squeeze_tag_checker.sv
design/wstc_checker.sv
tb/tb_top.sv
